### hdl/ngh_pkg.sv
package ngh_pkg;

	localparam int MAX_FIELD_CHARS        = 19;
	localparam int MINUTE_FRACTION_DIGITS = 5;
	localparam int FRAC_KEEP              = 6;
	localparam int QUEUE_DEPTH            = 4;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_H      = 8'h48;
	localparam logic [7:0] CH_D      = 8'h44;
	localparam logic [7:0] CH_T      = 8'h54;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_N      = 8'h4e;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_HDR  = 2'd1;
	localparam logic [1:0] MODE_GGA  = 2'd2;
	localparam logic [1:0] MODE_HDT  = 2'd3;

	localparam logic [3:0] FLD_TIME = 4'd1;
	localparam logic [3:0] FLD_LAT  = 4'd2;
	localparam logic [3:0] FLD_NS   = 4'd3;
	localparam logic [3:0] FLD_LON  = 4'd4;
	localparam logic [3:0] FLD_EW   = 4'd5;
	localparam logic [3:0] FLD_QUAL = 4'd6;
	localparam logic [3:0] FLD_SATS = 4'd7;
	localparam logic [3:0] FLD_HDOP = 4'd8;
	localparam logic [3:0] FLD_ALT  = 4'd9;
	localparam logic [3:0] FLD_HEAD = 4'd1;
	localparam logic [3:0] FLD_REF  = 4'd2;
	localparam logic [3:0] FLD_LAST = 4'd15;

	localparam logic [33:0] WHOLE_LIMIT = 34'h3_ffff_ffff;

	function automatic int pow10_int(input int e);
		int v;
		v = 1;
		for (int i = 0; i < e; i++) v = v * 10;
		return v;
	endfunction

	localparam logic [23:0] DEG_SCALE = 24'd10000000;
	localparam logic [16:0] MIN_SCALE = 17'(pow10_int(7 - MINUTE_FRACTION_DIGITS));

	function automatic logic [19:0] pow10_small(input logic [2:0] e);
		logic [19:0] v;
		case (e)
			3'd0: v = 20'd1;
			3'd1: v = 20'd10;
			3'd2: v = 20'd100;
			3'd3: v = 20'd1000;
			3'd4: v = 20'd10000;
			3'd5: v = 20'd100000;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

	typedef struct packed {
		logic        clr;
		logic        commit;
		logic        emit;
		logic        hdt;
		logic [3:0]  fld;
		logic [33:0] whole;
		logic [6:0]  f2;
		logic        minus;
		logic [9:0]  deg;
		logic [19:0] wmin;
		logic [19:0] fm;
		logic [2:0]  flags;
	} tok_t;

	typedef struct packed {
		logic               sentence_kind;
		logic [26:0]        fix_time;
		logic [29:0]        latitude;
		logic               north;
		logic [33:0]        longitude;
		logic               east;
		logic [6:0]         fix_quality;
		logic [6:0]         satellites;
		logic [16:0]        hdop;
		logic signed [24:0] altitude;
		logic [16:0]        heading;
		logic               true_north;
	} rec_t;

endpackage

### hdl/ngh_front.sv
module ngh_front
	import ngh_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  logic [7:0] char_byte,
	output logic       tok_push,
	output tok_t       tok
);

	logic [1:0]  mode_q, mode_n;
	logic [2:0]  hp_q, hp_n;
	logic [3:0]  fld_q, fld_n;
	logic [4:0]  chars_q, chars_n;
	logic [33:0] whole_q, whole_n;
	logic [6:0]  f2_q, f2_n;
	logic [19:0] fm_q, fm_n;
	logic [2:0]  fdc_q, fdc_n;
	logic        minus_q, minus_n;
	logic [9:0]  deg_q, deg_n;
	logic [2:0]  flags_q, flags_n;

	logic [1:0]  dc;
	logic        short_fld;
	logic [37:0] wx;
	logic [3:0]  dig;
	logic [2:0]  nfr;
	tok_t        ftok;

	always_comb begin
		dc = 2'd0;
		if (mode_q == MODE_GGA && fld_q == FLD_LAT) dc = 2'd2;
		if (mode_q == MODE_GGA && fld_q == FLD_LON) dc = 2'd3;
		short_fld = chars_q <= {3'b0, dc};
		ftok        = '0;
		ftok.hdt    = mode_q == MODE_HDT;
		ftok.fld    = fld_q;
		ftok.whole  = whole_q;
		ftok.f2     = f2_q;
		ftok.minus  = minus_q;
		ftok.flags  = flags_q;
		ftok.deg    = short_fld ? ((whole_q > 34'd999) ? 10'd999 : whole_q[9:0]) : deg_q;
		ftok.wmin   = short_fld ? 20'd0 :
			((whole_q > 34'd999999) ? 20'd999999 : whole_q[19:0]);
		ftok.fm     = short_fld ? 20'd0 : fm_q;
	end

	always_comb begin
		mode_n = mode_q; hp_n = hp_q; fld_n = fld_q; chars_n = chars_q;
		whole_n = whole_q; f2_n = f2_q; fm_n = fm_q; fdc_n = fdc_q;
		minus_n = minus_q; deg_n = deg_q; flags_n = flags_q;
		tok_push = 1'b0;
		tok = ftok;
		wx = '0;
		dig = char_byte[3:0];
		nfr = '0;
		if (acc) begin
			if (char_byte == CH_DOLLAR) begin
				mode_n = MODE_HDR;
				hp_n = 3'd0;
			end else begin
				case (mode_q)
					MODE_IDLE: begin
					end
					MODE_HDR: begin
						mode_n = MODE_IDLE;
						if (hp_q == 3'd0 && char_byte == CH_G) begin
							mode_n = MODE_HDR; hp_n = 3'd1;
						end else if (hp_q == 3'd1 && char_byte == CH_P) begin
							mode_n = MODE_HDR; hp_n = 3'd2;
						end else if (hp_q == 3'd2 && char_byte == CH_G) begin
							mode_n = MODE_HDR; hp_n = 3'd3;
						end else if (hp_q == 3'd2 && char_byte == CH_H) begin
							mode_n = MODE_HDR; hp_n = 3'd5;
						end else if (hp_q == 3'd3 && char_byte == CH_G) begin
							mode_n = MODE_HDR; hp_n = 3'd4;
						end else if (hp_q == 3'd5 && char_byte == CH_D) begin
							mode_n = MODE_HDR; hp_n = 3'd6;
						end else if ((hp_q == 3'd4 && char_byte == CH_A) ||
						             (hp_q == 3'd6 && char_byte == CH_T)) begin
							mode_n = (hp_q == 3'd4) ? MODE_GGA : MODE_HDT;
							fld_n = '0; chars_n = '0; whole_n = '0; f2_n = '0;
							fm_n = '0; fdc_n = '0; minus_n = 1'b0; flags_n = '0;
							tok = '0;
							tok.clr = 1'b1;
							tok_push = 1'b1;
						end
					end
					default: begin
						if (char_byte == CH_CR) begin
							tok.emit = 1'b1;
							tok.commit = fld_q != 4'd0;
							tok_push = 1'b1;
							mode_n = MODE_IDLE;
						end else if (fld_q == 4'd0 || char_byte == CH_COMMA) begin
							if (fld_q != 4'd0) begin
								tok.commit = 1'b1;
								tok_push = 1'b1;
							end
							if (fld_q != FLD_LAST) fld_n = fld_q + 4'd1;
							chars_n = '0; whole_n = '0; f2_n = '0; fm_n = '0;
							fdc_n = '0; minus_n = 1'b0;
						end else if (chars_q < 5'(MAX_FIELD_CHARS)) begin
							if (chars_q == 5'd0) begin
								if (mode_q == MODE_GGA && fld_q == FLD_NS && char_byte == CH_N)
									flags_n[0] = 1'b1;
								if (mode_q == MODE_GGA && fld_q == FLD_EW && char_byte == CH_E)
									flags_n[1] = 1'b1;
								if (mode_q == MODE_HDT && fld_q == FLD_REF && char_byte == CH_T)
									flags_n[2] = 1'b1;
							end
							// degree digits done: park them, restart number for minutes
							if (dc != 2'd0 && chars_q == {3'b0, dc}) begin
								deg_n = whole_q[9:0];
								whole_n = '0; f2_n = '0; fm_n = '0; fdc_n = '0; minus_n = 1'b0;
							end
							if (char_byte >= CH_ZERO && char_byte <= CH_NINE) begin
								if (fdc_n == 3'd0) begin
									wx = {1'b0, whole_n, 3'b0} + {3'b0, whole_n, 1'b0} +
										{34'b0, dig};
									whole_n = (wx > {4'b0, WHOLE_LIMIT}) ? WHOLE_LIMIT : wx[33:0];
								end else if (fdc_n <= 3'(FRAC_KEEP)) begin
									nfr = fdc_n - 3'd1;
									if (nfr == 3'd0) f2_n = f2_n + 7'(dig) * 7'd10;
									if (nfr == 3'd1) f2_n = f2_n + 7'(dig);
									if (nfr < 3'(MINUTE_FRACTION_DIGITS))
										fm_n = fm_n + 20'(dig) *
											pow10_small(3'(MINUTE_FRACTION_DIGITS - 1) - nfr);
									fdc_n = fdc_n + 3'd1;
								end
							end else if (char_byte == CH_DOT) begin
								if (fdc_n == 3'd0) fdc_n = 3'd1;
							end else if (char_byte == CH_MINUS) begin
								if (chars_q == 5'd0) minus_n = 1'b1;
							end
							chars_n = chars_q + 5'd1;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; hp_q <= '0; fld_q <= '0; chars_q <= '0;
			whole_q <= '0; f2_q <= '0; fm_q <= '0; fdc_q <= '0; minus_q <= 1'b0;
			deg_q <= '0; flags_q <= '0;
		end else begin
			mode_q <= mode_n; hp_q <= hp_n; fld_q <= fld_n; chars_q <= chars_n;
			whole_q <= whole_n; f2_q <= f2_n; fm_q <= fm_n; fdc_q <= fdc_n;
			minus_q <= minus_n; deg_q <= deg_n; flags_q <= flags_n;
		end
	end

endmodule

### hdl/ngh_tokq.sv
module ngh_tokq
	import ngh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  tok_t wdata,
	input  logic rd,
	output tok_t rdata,
	output logic full,
	output logic empty
);

	tok_t       mem_q [QUEUE_DEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign full  = cnt_q == 3'(QUEUE_DEPTH);
	assign empty = cnt_q == 3'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr && !full) wp_q <= wp_q + 2'd1;
			if (rd && !empty) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr && !full) - 3'(rd && !empty);
		end
	end

endmodule

### hdl/ngh_back.sv
module ngh_back
	import ngh_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  tok_t tq_head,
	input  logic tq_empty,
	output logic tq_pop,
	input  logic pop,
	output logic empty,
	output rec_t rec
);

	localparam int DIV_STAGES = 6;

	typedef struct packed {
		logic        vld;
		tok_t        tok;
		logic [40:0] hund;
		logic [33:0] pdeg;
		logic [41:0] x;
		logic [41:0] q;
		logic [3:0]  r;
	} dstage_t;

	// seven quotient bits of a divide by fifteen
	function automatic dstage_t div_step(input dstage_t s);
		dstage_t o;
		logic [4:0] t;
		o = s;
		for (int j = 0; j < 7; j++) begin
			t = {o.r, o.x[41]};
			o.x = {o.x[40:0], 1'b0};
			if (t >= 5'd15) begin
				o.q = {o.q[40:0], 1'b1};
				o.r = 4'(t - 5'd15);
			end else begin
				o.q = {o.q[40:0], 1'b0};
				o.r = t[3:0];
			end
		end
		return o;
	endfunction

	logic        adv;
	logic        vld_s1;
	tok_t        tok_s1;
	logic [43:0] pw_s1, pf_s1;
	logic [33:0] pdeg_s1;
	logic [40:0] ph_s1;
	dstage_t     div_s [DIV_STAGES + 1];
	dstage_t     fin;
	logic [43:0] x_sum;

	logic [26:0]        time_q;
	logic [29:0]        lat_q;
	logic [33:0]        lon_q;
	logic [6:0]         qual_q, sats_q;
	logic [16:0]        hdop_q;
	logic signed [24:0] alt_q;
	logic [26:0]        time_n;
	logic [29:0]        lat_n;
	logic [33:0]        lon_n;
	logic [6:0]         qual_n, sats_n;
	logic [16:0]        hdop_n;
	logic signed [24:0] alt_n;
	logic [43:0]        total;
	logic [40:0]        h;
	rec_t               rec_n;

	rec_t       oq_q [QUEUE_DEPTH];
	logic [1:0] owp_q, orp_q;
	logic [2:0] ocnt_q;
	logic       opush;

	assign adv    = ocnt_q < 3'(QUEUE_DEPTH);
	assign tq_pop = adv && !tq_empty;
	assign fin    = div_s[DIV_STAGES];
	assign x_sum  = pw_s1 + pf_s1;

	always_comb begin
		h = fin.hund;
		total = {10'b0, fin.pdeg} + {2'b0, fin.q};
		time_n = time_q; lat_n = lat_q; lon_n = lon_q; qual_n = qual_q;
		sats_n = sats_q; hdop_n = hdop_q; alt_n = alt_q;
		if (fin.tok.clr) begin
			time_n = '0; lat_n = '0; lon_n = '0; qual_n = '0;
			sats_n = '0; hdop_n = '0; alt_n = '0;
		end else if (fin.tok.commit) begin
			if (fin.tok.hdt) begin
				if (fin.tok.fld == FLD_HEAD)
					hdop_n = fin.tok.minus ? '0 : (h > 41'd99999 ? 17'd99999 : h[16:0]);
			end else begin
				case (fin.tok.fld)
					FLD_TIME: time_n = fin.tok.minus ? '0 :
						(h > 41'd99999999 ? 27'd99999999 : h[26:0]);
					FLD_LAT: lat_n = total > 44'd999999999 ? 30'd999999999 : total[29:0];
					FLD_LON: lon_n = total > 44'd9999999999 ? 34'd9999999999 : total[33:0];
					FLD_QUAL: qual_n = fin.tok.minus ? '0 :
						(fin.tok.whole > 34'd99 ? 7'd99 : fin.tok.whole[6:0]);
					FLD_SATS: sats_n = fin.tok.minus ? '0 :
						(fin.tok.whole > 34'd99 ? 7'd99 : fin.tok.whole[6:0]);
					FLD_HDOP: hdop_n = fin.tok.minus ? '0 :
						(h > 41'd99999 ? 17'd99999 : h[16:0]);
					FLD_ALT: alt_n = fin.tok.minus ?
						(h > 41'd100000 ? -25'sd100000 : -$signed(25'(h))) :
						(h > 41'd10000000 ? 25'sd10000000 : $signed(25'(h)));
					default: begin
					end
				endcase
			end
		end
		rec_n = '0;
		if (fin.tok.hdt) begin
			rec_n.sentence_kind = 1'b1;
			rec_n.heading       = hdop_n;
			rec_n.true_north    = fin.tok.flags[2];
		end else begin
			rec_n.fix_time    = time_n;
			rec_n.latitude    = lat_n;
			rec_n.north       = fin.tok.flags[0];
			rec_n.longitude   = lon_n;
			rec_n.east        = fin.tok.flags[1];
			rec_n.fix_quality = qual_n;
			rec_n.satellites  = sats_n;
			rec_n.hdop        = hdop_n;
			rec_n.altitude    = alt_n;
		end
	end

	assign opush = adv && fin.vld && fin.tok.emit;

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_s1  <= tq_head;
			pw_s1   <= 44'(tq_head.wmin) * 44'(DEG_SCALE);
			pf_s1   <= 44'(tq_head.fm) * 44'(MIN_SCALE);
			pdeg_s1 <= 34'(tq_head.deg) * 34'(DEG_SCALE);
			ph_s1   <= 41'(tq_head.whole) * 41'd100;
		end
		if (opush) oq_q[owp_q] <= rec_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int i = 0; i <= DIV_STAGES; i++) div_s[i] <= '0;
			time_q <= '0; lat_q <= '0; lon_q <= '0; qual_q <= '0;
			sats_q <= '0; hdop_q <= '0; alt_q <= '0;
		end else if (adv) begin
			vld_s1 <= !tq_empty;
			div_s[0].vld  <= vld_s1;
			div_s[0].tok  <= tok_s1;
			div_s[0].hund <= ph_s1 + 41'(tok_s1.f2);
			div_s[0].pdeg <= pdeg_s1;
			div_s[0].x    <= x_sum[43:2];
			div_s[0].q    <= '0;
			div_s[0].r    <= '0;
			for (int i = 0; i < DIV_STAGES; i++) div_s[i + 1] <= div_step(div_s[i]);
			if (fin.vld) begin
				time_q <= time_n; lat_q <= lat_n; lon_q <= lon_n; qual_q <= qual_n;
				sats_q <= sats_n; hdop_q <= hdop_n; alt_q <= alt_n;
			end
		end
	end

	assign empty = ocnt_q == 3'd0;
	assign rec   = oq_q[orp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0; orp_q <= '0; ocnt_q <= '0;
		end else begin
			if (opush) owp_q <= owp_q + 2'd1;
			if (pop && !empty) orp_q <= orp_q + 2'd1;
			ocnt_q <= ocnt_q + 3'(opush) - 3'(pop && !empty);
		end
	end

endmodule

### hdl/nmea_gga_hdt_sentence_parser.sv
// NMEA GGA / HDT sentence parser.
// Input channel: one text byte per beat on char_byte; a beat moves when push is
// high and full is low. Result channel: one record per beat; the oldest record
// sits on the result ports while empty is low and leaves when pop is high.
// A record appears for every carriage return that closes a "$GPGGA" or
// "$GPHDT" sentence; other text produces nothing.
// Throughput: one byte per cycle sustained while full is low. The front
// classifier updates its registered field state on each accepted byte and
// sends a field token on each field-closing comma, carriage return or header;
// the back end is an eight register pipeline (multipliers, a sum stage, then
// six stages of a divide by fifteen that finishes the minutes-over-sixty
// scaling) that also takes one token a cycle while the record queue has room.
// Tokens pass the token queue and back pipeline; records wait in the record queue.
// Stalls: when the four entry record queue fills, the back pipeline holds; the
// four entry token queue then fills and full rises, holding the input side.
// Reset: arst_n clears the parser to idle and empties both queues.
module nmea_gga_hdt_sentence_parser
	import ngh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         char_byte,
	output logic               empty,
	input  logic               pop,
	output logic               sentence_kind,
	output logic [26:0]        fix_time,
	output logic [29:0]        latitude,
	output logic               north,
	output logic [33:0]        longitude,
	output logic               east,
	output logic [6:0]         fix_quality,
	output logic [6:0]         satellites,
	output logic [16:0]        hdop,
	output logic signed [24:0] altitude,
	output logic [16:0]        heading,
	output logic               true_north
);

	logic tok_push, tq_full, tq_empty, tq_pop;
	tok_t tok, tq_head;
	rec_t rec;

	// hold input while token queue is full
	assign full = tq_full;

	ngh_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (push && !tq_full),
		.char_byte (char_byte),
		.tok_push  (tok_push),
		.tok       (tok)
	);

	ngh_tokq u_tokq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tok_push),
		.wdata  (tok),
		.rd     (tq_pop),
		.rdata  (tq_head),
		.full   (tq_full),
		.empty  (tq_empty)
	);

	ngh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.tq_head  (tq_head),
		.tq_empty (tq_empty),
		.tq_pop   (tq_pop),
		.pop      (pop),
		.empty    (empty),
		.rec      (rec)
	);

	assign sentence_kind = rec.sentence_kind;
	assign fix_time      = rec.fix_time;
	assign latitude      = rec.latitude;
	assign north         = rec.north;
	assign longitude     = rec.longitude;
	assign east          = rec.east;
	assign fix_quality   = rec.fix_quality;
	assign satellites    = rec.satellites;
	assign hdop          = rec.hdop;
	assign altitude      = rec.altitude;
	assign heading       = rec.heading;
	assign true_north    = rec.true_north;

endmodule

### hdl/ngh_checker.sv
module ngh_props (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               sentence_kind,
	input logic [26:0]        fix_time,
	input logic [29:0]        latitude,
	input logic [33:0]        longitude,
	input logic [6:0]         fix_quality,
	input logic [6:0]         satellites,
	input logic [16:0]        hdop,
	input logic signed [24:0] altitude,
	input logic [16:0]        heading,
	input logic               true_north
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(fix_time) && $stable(latitude) && $stable(heading)))
		else $error("waiting record changed");

	a_hdt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && sentence_kind) |->
		(fix_time == 27'd0 && latitude == 30'd0 && longitude == 34'd0 && hdop == 17'd0))
		else $error("heading record carries position data");

	a_gga_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !sentence_kind) |-> (heading == 17'd0 && !true_north))
		else $error("position record carries heading data");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (fix_quality <= 7'd99 && satellites <= 7'd99 && hdop <= 17'd99999 &&
		altitude >= -25'sd100000 && altitude <= 25'sd10000000))
		else $error("record value out of range");

endmodule

bind nmea_gga_hdt_sentence_parser ngh_props u_ngh_props (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.sentence_kind (sentence_kind),
	.fix_time      (fix_time),
	.latitude      (latitude),
	.longitude     (longitude),
	.fix_quality   (fix_quality),
	.satellites    (satellites),
	.hdop          (hdop),
	.altitude      (altitude),
	.heading       (heading),
	.true_north    (true_north)
);

### sim/ngh_checker.sv
module ngh_checker
	import ngh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         char_byte,
	input  logic               empty,
	input  logic               pop,
	input  logic               sentence_kind,
	input  logic [26:0]        fix_time,
	input  logic [29:0]        latitude,
	input  logic               north,
	input  logic [33:0]        longitude,
	input  logic               east,
	input  logic [6:0]         fix_quality,
	input  logic [6:0]         satellites,
	input  logic [16:0]        hdop,
	input  logic signed [24:0] altitude,
	input  logic [16:0]        heading,
	input  logic               true_north,
	output int                 fail_count,
	output int                 records_due
);
	timeunit 1ns;
	timeprecision 1ps;

	// parser shadow state
	logic [1:0]  mode;
	logic [2:0]  hpos;
	logic [3:0]  fnum;
	logic [4:0]  nch;
	logic [63:0] whole;
	logic [63:0] frac;
	logic [2:0]  fcnt;
	logic        neg;
	logic [63:0] h_time, h_lat, h_lon, h_hdop;
	logic [2:0]  h_flags;
	logic [6:0]  h_qual, h_sats;
	longint      h_alt;

	rec_t record_fifo[$];

	function automatic logic [63:0] p10(input int e);
		logic [63:0] v;
		v = 1;
		for (int i = 0; i < e; i++) v = v * 10;
		return v;
	endfunction

	function automatic logic [63:0] frac_k(input int k);
		int n;
		n = (fcnt != 0) ? fcnt - 1 : 0;
		if (n > FRAC_KEEP) n = FRAC_KEEP;
		if (k > FRAC_KEEP) k = FRAC_KEEP;
		if (n >= k) return frac / p10(n - k);
		return frac * p10(k - n);
	endfunction

	function automatic logic [63:0] sat_u(input logic [63:0] v, input logic [63:0] lim);
		if (neg) return 0;
		return (v > lim) ? lim : v;
	endfunction

	function automatic int deg_chars();
		if (mode != MODE_GGA) return 0;
		if (fnum == FLD_LAT) return 2;
		if (fnum == FLD_LON) return 3;
		return 0;
	endfunction

	function automatic logic [63:0] angle(input logic [63:0] lim);
		logic [63:0] deg, mf, w, total;
		mf = 0;
		if (nch <= deg_chars()) deg = whole;
		else begin
			deg = (fnum == FLD_LAT) ? h_lat : h_lon;
			w = (whole > 999999) ? 999999 : whole;
			mf = w * p10(MINUTE_FRACTION_DIGITS) + frac_k(MINUTE_FRACTION_DIGITS);
		end
		if (deg > 999) deg = 999;
		total = deg * 10000000 + mf * p10(7 - MINUTE_FRACTION_DIGITS) / 60;
		return (total > lim) ? lim : total;
	endfunction

	task automatic clear_number();
		whole = 0; frac = 0; fcnt = 0; neg = 0;
	endtask

	task automatic start_sentence(input logic [1:0] m);
		mode = m; fnum = 0; nch = 0;
		clear_number();
		h_time = 0; h_lat = 0; h_lon = 0; h_hdop = 0; h_flags = 0;
		h_qual = 0; h_sats = 0; h_alt = 0;
	endtask

	task automatic close_field();
		logic [63:0] v;
		v = whole * 100 + frac_k(2);
		if (mode == MODE_HDT) begin
			if (fnum == FLD_HEAD) h_hdop = sat_u(v, 99999);
		end else begin
			case (fnum)
				FLD_TIME: h_time = sat_u(v, 99999999);
				FLD_LAT:  h_lat = angle(999999999);
				FLD_LON:  h_lon = angle(64'd9999999999);
				FLD_QUAL: h_qual = 7'(sat_u(whole, 99));
				FLD_SATS: h_sats = 7'(sat_u(whole, 99));
				FLD_HDOP: h_hdop = sat_u(v, 99999);
				FLD_ALT: begin
					if (neg) h_alt = (v > 100000) ? -100000 : -longint'(v);
					else h_alt = (v > 10000000) ? 10000000 : longint'(v);
				end
				default: ;
			endcase
		end
	endtask

	task automatic field_char(input logic [7:0] c);
		int dc;
		logic [63:0] w;
		dc = deg_chars();
		if (nch >= MAX_FIELD_CHARS) return;
		if (nch == 0) begin
			if (mode == MODE_GGA && fnum == FLD_NS && c == CH_N) h_flags[0] = 1;
			if (mode == MODE_GGA && fnum == FLD_EW && c == CH_E) h_flags[1] = 1;
			if (mode == MODE_HDT && fnum == FLD_REF && c == CH_T) h_flags[2] = 1;
		end
		// degree part done: park it and restart for minutes
		if (dc != 0 && nch == dc) begin
			if (fnum == FLD_LAT) h_lat = whole;
			else h_lon = whole;
			clear_number();
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (fcnt == 0) begin
				w = whole * 10 + (c - CH_ZERO);
				whole = (w > WHOLE_LIMIT) ? WHOLE_LIMIT : w;
			end else if (fcnt <= FRAC_KEEP) begin
				frac = frac * 10 + (c - CH_ZERO);
				fcnt++;
			end
		end else if (c == CH_DOT) begin
			if (fcnt == 0) fcnt = 1;
		end else if (c == CH_MINUS) begin
			if (nch == 0) neg = 1;
		end
		nch++;
	endtask

	task automatic predict_byte(input logic [7:0] c);
		rec_t r;
		if (c == CH_DOLLAR) begin
			mode = MODE_HDR; hpos = 0;
			return;
		end
		if (mode == MODE_IDLE) return;
		if (mode == MODE_HDR) begin
			if (hpos == 0 && c == CH_G) hpos = 1;
			else if (hpos == 1 && c == CH_P) hpos = 2;
			else if (hpos == 2 && c == CH_G) hpos = 3;
			else if (hpos == 2 && c == CH_H) hpos = 5;
			else if (hpos == 3 && c == CH_G) hpos = 4;
			else if (hpos == 4 && c == CH_A) start_sentence(MODE_GGA);
			else if (hpos == 5 && c == CH_D) hpos = 6;
			else if (hpos == 6 && c == CH_T) start_sentence(MODE_HDT);
			else mode = MODE_IDLE;
			return;
		end
		if (c == CH_CR) begin
			if (fnum > 0) close_field();
			r = '0;
			if (mode == MODE_HDT) begin
				r.sentence_kind = 1;
				r.heading = h_hdop[16:0];
				r.true_north = h_flags[2];
			end else begin
				r.fix_time = h_time[26:0];
				r.latitude = h_lat[29:0];
				r.north = h_flags[0];
				r.longitude = h_lon[33:0];
				r.east = h_flags[1];
				r.fix_quality = h_qual;
				r.satellites = h_sats;
				r.hdop = h_hdop[16:0];
				r.altitude = 25'(h_alt);
			end
			record_fifo.push_back(r);
			mode = MODE_IDLE;
			return;
		end
		if (fnum == 0) begin
			// separator slot: whatever byte it is
			fnum = 1; nch = 0;
			clear_number();
			return;
		end
		if (c == CH_COMMA) begin
			close_field();
			if (fnum < FLD_LAST) fnum++;
			nch = 0;
			clear_number();
			return;
		end
		field_char(c);
	endtask

	rec_t got, want;
	assign got = '{sentence_kind, fix_time, latitude, north, longitude, east,
		fix_quality, satellites, hdop, altitude, heading, true_north};
	assign records_due = record_fifo.size();

	initial begin
		fail_count = 0;
		mode = MODE_IDLE; hpos = 0;
		start_sentence(MODE_IDLE);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			// compare first so a record can't match its own byte's prediction
			if (pop && !empty) begin
				if (record_fifo.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected record %p", got);
				end else begin
					want = record_fifo.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("record mismatch\n  exp %p\n  got %p", want, got);
					end
				end
			end
			if (push && !full) predict_byte(char_byte);
		end
	end
endmodule

### sim/tb_top.sv
module tb_top;
	import ngh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic               clk, arst_n, push, pop;
	logic [7:0]         char_byte;
	logic               full, empty;
	logic               sentence_kind, north, east, true_north;
	logic [26:0]        fix_time;
	logic [29:0]        latitude;
	logic [33:0]        longitude;
	logic [6:0]         fix_quality, satellites;
	logic [16:0]        hdop, heading;
	logic signed [24:0] altitude;
	int                 fail_count, records_due;

	// byte stream to send, built up front
	logic [7:0] text_q[$];
	// idling knobs; zero means never idle
	int push_idle_pct, pop_idle_pct;
	int quiet_cycles;
	bit stim_done;

	nmea_gga_hdt_sentence_parser u_dut (
		.clk, .arst_n, .push, .full, .char_byte, .empty, .pop,
		.sentence_kind, .fix_time, .latitude, .north, .longitude, .east,
		.fix_quality, .satellites, .hdop, .altitude, .heading, .true_north
	);

	ngh_checker u_chk (
		.clk, .arst_n, .push, .full, .char_byte, .empty, .pop,
		.sentence_kind, .fix_time, .latitude, .north, .longitude, .east,
		.fix_quality, .satellites, .hdop, .altitude, .heading, .true_north,
		.fail_count, .records_due
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endtask

	// random decimal text: digits with optional sign, dot and extra junk
	function automatic string rand_num(input int maxlen);
		string s;
		int n;
		s = "";
		n = $urandom_range(0, maxlen);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: s = {s, "."};
				1: s = {s, "-"};
				2: s = {s, "x"};
				default: s = {s, string'(8'($urandom_range(48, 57)))};
			endcase
		end
		if ($urandom_range(0, 3) == 0) s = {"-", s};
		return s;
	endfunction

	function automatic string rand_coord(input int degs);
		string s;
		s = "";
		for (int i = 0; i < degs; i++) s = {s, string'(8'($urandom_range(48, 57)))};
		s = {s, $sformatf("%02d.", $urandom_range(0, 59))};
		for (int i = $urandom_range(0, 8); i > 0; i--)
			s = {s, string'(8'($urandom_range(48, 57)))};
		if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, degs) - 1);
		return s;
	endfunction

	task automatic put_gga();
		string s;
		s = {"$GPGGA,", rand_num(12), ",", rand_coord(2), ",",
			($urandom_range(0, 1) ? "N" : "S"), ",", rand_coord(3), ",",
			($urandom_range(0, 1) ? "E" : "W"), ",", rand_num(3), ",", rand_num(3), ",",
			rand_num(7), ",", rand_num(9), ",M,", rand_num(4), ",M,,*47"};
		// truncate now and then, so fewer fields than usual come through
		if ($urandom_range(0, 7) == 0) s = s.substr(0, $urandom_range(6, s.len() - 1));
		put_str(s);
		text_q.push_back(CH_CR);
		text_q.push_back(8'h0a);
	endtask

	task automatic put_hdt();
		put_str({"$GPHDT,", rand_num(9), ",", ($urandom_range(0, 1) ? "T" : "M"), "*1C"});
		text_q.push_back(CH_CR);
		text_q.push_back(8'h0a);
	endtask

	initial begin
		int kind;
		// directed: extremes, saturation, empty fields, broken headers
		put_str("$GPGGA,235959.999,8959.99999,N,17959.99999,E,99,99,999.99,99999.99,M\r");
		put_str("$GPGGA,99999999999999999999,99999999,N,99999999,E,999,999,9999999,");
		put_str("99999999,M\r");
		put_str("$GPGGA,,,,,,,,,-99999999\r");
		put_str("$GPGGA,-5,-4530.5,S,-1,W,-3,-4,-1.5,-12.3456\r");
		put_str("$GPGGA\r$GPHDT\r$GPGGAX1.2.3,4\r");
		put_str("$GPHDT,359.99,T*0C\r$GPHDT,-1,M\r$GPHDT,1234567.891,T\r");
		put_str("$GPGSV,1,2,3\r$GPGX$GPHDT,1.5,T$GPHDT,12.345678901,T,,,,,,,,,,,,,,,,,1\r");
		put_str("$G\r$GPGGA,1,2,N,3,E,4,5,6,7,a,b,c,d,e,f,g,h\r");
		text_q.push_back(8'hff); text_q.push_back(8'h00); text_q.push_back(8'h80);
		// random: mostly well-formed sentences, some noise
		while (text_q.size() < 1900) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) put_gga();
			else if (kind < 9) put_hdt();
			else for (int i = $urandom_range(1, 8); i > 0; i--)
				text_q.push_back(8'($urandom_range(0, 255)));
		end
	end

	// input side: send bytes, idle at random
	initial begin
		push = 0; pop = 0; char_byte = 0; stim_done = 0;
		push_idle_pct = 16; pop_idle_pct = 16;
		arst_n = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1;
		while (text_q.size() > 0) begin
			@(posedge clk);
			// hold the beat while it waits on full
			if (push && full) continue;
			if (push) void'(text_q.pop_front());
			@(negedge clk);
			if (text_q.size() == 0) begin
				push = 0;
				break;
			end
			// quiet stretch with no idling in the middle
			if (text_q.size() < 1300 && text_q.size() > 900) begin
				push_idle_pct = 0; pop_idle_pct = 0;
			end else begin
				push_idle_pct = 16; pop_idle_pct = 16;
			end
			if ($urandom_range(0, 99) < push_idle_pct) push = 0;
			else begin
				push = 1;
				char_byte = text_q[0];
			end
		end
		stim_done = 1;
	end

	// result side: stall pop at random
	always @(negedge clk) begin
		if (arst_n) pop <= ($urandom_range(0, 99) >= pop_idle_pct);
	end

	// watchdog: cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 2000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		wait (stim_done);
		while (records_due != 0) @(posedge clk);
		// drain time for anything stray still in the pipe
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule
